@@ hdl/summed_area_table_engine_core_defines.svh @@
// Assertion macros for the summed-area table engine.
`ifndef SUMMED_AREA_TABLE_ENGINE_CORE_DEFINES_SVH
`define SUMMED_AREA_TABLE_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SATE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sate check failed");

// Next-cycle implication, checked out of reset.
`define SATE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sate check failed");

`endif

@@ hdl/sate_pkg.sv @@
// Shared constants and codes of the summed-area table engine.
package sate_pkg;

    localparam int IDX_W     = 7;
    localparam int VALUE_W   = 32;
    localparam int RESULT_W  = 48;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;

    // grid bounds, tied to the 7-bit index fields
    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam op_t OP_ADD   = 3'd0;
    localparam op_t OP_SET   = 3'd1;
    localparam op_t OP_GET   = 3'd2;
    localparam op_t OP_BUILD = 3'd3;
    localparam op_t OP_SUM   = 3'd4;
    localparam op_t OP_CLEAR = 3'd5;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_PHASE = 2'd1;
    localparam status_t STATUS_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    localparam idx_t CFG_RESET = 7'd64;

endpackage

@@ hdl/summed_area_table_engine_core.sv @@
// Summed-area table engine: grid store, in-place prefix build and rectangle sums.
//
// Requests come in on start/op/row/col/row_end/col_end/value/expect_built and are
// taken at a clock edge with start high and busy low. Every request gives one
// result on result/status, shown for exactly one cycle with done high; the
// receiver cannot stall, and a new request may be taken in the cycle done is high.
// Sizes are set through cfg_we/cfg_index/cfg_data by the user, only while busy
// is low; the block itself does not enforce it.
// Steps from accept to the done strobe (next request taken in that cycle):
//   set, ignored op codes and any error: answered straight from idle
//   add: read of the cell, then write-back of the sum; get: read of the cell
//   rectangle sum: four corner reads through the single memory port
//   build: two passes, each cell read then written back
//   clear: a sweep of the whole memory to zero
// The grid memory is single-port: one access per cycle.
// After reset the block sweeps the whole memory to zero with busy high and
// gives no result; configuration writes are taken during the sweep.
module summed_area_table_engine_core #(
    parameter int SUM_WIDTH = 48
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  sate_pkg::op_t                          op,
    input  sate_pkg::idx_t                         row,
    input  sate_pkg::idx_t                         col,
    input  sate_pkg::idx_t                         row_end,
    input  sate_pkg::idx_t                         col_end,
    input  logic signed [sate_pkg::VALUE_W-1:0]    value,
    input  logic                                   expect_built,
    output logic                                   done,
    output logic signed [sate_pkg::RESULT_W-1:0]   result,
    output sate_pkg::status_t                      status,
    input  logic                                   cfg_we,
    input  logic [sate_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sate_pkg::CFG_W-1:0]             cfg_data
);

    localparam int ROW_AW = (sate_pkg::MAX_ROWS > 1) ? $clog2(sate_pkg::MAX_ROWS) : 1;
    localparam int COL_AW = (sate_pkg::MAX_COLS > 1) ? $clog2(sate_pkg::MAX_COLS) : 1;
    localparam int AW     = ROW_AW + COL_AW;
    localparam int DEPTH  = sate_pkg::MAX_ROWS * (2 ** COL_AW);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CLR  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_GET  = 3'd3;
    localparam logic [2:0] ST_BRD  = 3'd4;
    localparam logic [2:0] ST_BWR  = 3'd5;
    localparam logic [2:0] ST_SUM  = 3'd6;

    typedef logic [SUM_WIDTH-1:0] sum_t;
    typedef logic [AW-1:0]        addr_t;

    // grid memory
    sum_t  mem [DEPTH];
    sum_t  mem_rdata_reg;
    addr_t mem_addr;
    sum_t  mem_wdata;
    logic  mem_we;

    logic [2:0]     state_reg, state_next;
    logic           built_reg, built_next;
    sate_pkg::idx_t rows_cfg_reg, rows_cfg_next;
    sate_pkg::idx_t cols_cfg_reg, cols_cfg_next;
    addr_t          clr_cnt_reg, clr_cnt_next;
    logic           clr_reply_reg, clr_reply_next;
    logic           pass_reg, pass_next;
    sate_pkg::idx_t outer_reg, outer_next;
    sate_pkg::idx_t inner_reg, inner_next;
    logic [2:0]     k_reg, k_next;
    logic           zero_reg, zero_next;
    logic           neg_reg, neg_next;
    logic           done_reg, done_next;

    sate_pkg::idx_t r_reg, r_next;
    sate_pkg::idx_t c_reg, c_next;
    sate_pkg::idx_t re_reg, re_next;
    sate_pkg::idx_t ce_reg, ce_next;
    addr_t          addr_reg, addr_next;
    sum_t           val_reg, val_next;
    sum_t           carry_reg, carry_next;
    sum_t           acc_reg, acc_next;
    logic [sate_pkg::RESULT_W-1:0] result_reg, result_next;
    sate_pkg::status_t             status_reg, status_next;

    sate_pkg::idx_t rows_eff, cols_eff;
    sate_pkg::idx_t in_lim, out_lim;
    sate_pkg::idx_t corner_r, corner_c;
    logic           corner_zero;
    logic           phase_err, cell_oob, rect_oob;
    logic           inner_last, outer_last;
    sum_t           value_ext, bsum, term;
    addr_t          build_addr;

    function automatic addr_t cell_addr(input sate_pkg::idx_t r, input sate_pkg::idx_t c);
        return {ROW_AW'(r), COL_AW'(c)};
    endfunction

    // sign-extend or wrap a store value to the result width
    function automatic logic [sate_pkg::RESULT_W-1:0] to_out(input sum_t x);
        logic signed [SUM_WIDTH-1:0] s;
        s = signed'(x);
        return sate_pkg::RESULT_W'(s);
    endfunction

    // out-of-range sizes saturate into 1..MAX
    assign rows_eff = (rows_cfg_reg == '0) ? 7'd1 :
                      (rows_cfg_reg > sate_pkg::MAX_ROWS) ?
                      sate_pkg::IDX_W'(sate_pkg::MAX_ROWS) : rows_cfg_reg;
    assign cols_eff = (cols_cfg_reg == '0) ? 7'd1 :
                      (cols_cfg_reg > sate_pkg::MAX_COLS) ?
                      sate_pkg::IDX_W'(sate_pkg::MAX_COLS) : cols_cfg_reg;

    assign value_ext = SUM_WIDTH'(value);

    always_comb
    begin
        case (op)
            sate_pkg::OP_ADD, sate_pkg::OP_SET, sate_pkg::OP_BUILD: phase_err = built_reg;
            sate_pkg::OP_GET: phase_err = (expect_built != built_reg);
            sate_pkg::OP_SUM: phase_err = !built_reg;
            default:          phase_err = 1'b0;
        endcase
    end

    assign cell_oob = (row >= rows_eff) || (col >= cols_eff);
    assign rect_oob = (row > row_end) || (col > col_end) ||
                      (row_end > rows_eff) || (col_end > cols_eff);

    // build walk: pass 0 runs along rows, pass 1 down columns
    assign in_lim     = pass_reg ? rows_eff : cols_eff;
    assign out_lim    = pass_reg ? cols_eff : rows_eff;
    assign inner_last = (inner_reg == in_lim - 7'd1);
    assign outer_last = (outer_reg == out_lim - 7'd1);
    assign build_addr = pass_reg ? cell_addr(inner_reg, outer_reg)
                                 : cell_addr(outer_reg, inner_reg);
    assign bsum       = mem_rdata_reg + carry_reg;

    // corner order: (re,ce)+ (re,c)- (r,ce)- (r,c)+
    assign corner_r    = k_reg[1] ? r_reg : re_reg;
    assign corner_c    = k_reg[0] ? c_reg : ce_reg;
    assign corner_zero = (corner_r == '0) || (corner_c == '0);
    assign term        = zero_reg ? '0 :
                         (neg_reg ? (~mem_rdata_reg + SUM_WIDTH'(1)) : mem_rdata_reg);

    always_comb
    begin
        state_next     = state_reg;
        built_next     = built_reg;
        rows_cfg_next  = rows_cfg_reg;
        cols_cfg_next  = cols_cfg_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_reply_next = clr_reply_reg;
        pass_next      = pass_reg;
        outer_next     = outer_reg;
        inner_next     = inner_reg;
        k_next         = k_reg;
        zero_next      = zero_reg;
        neg_next       = neg_reg;
        done_next      = 1'b0;
        r_next         = r_reg;
        c_next         = c_reg;
        re_next        = re_reg;
        ce_next        = ce_reg;
        addr_next      = addr_reg;
        val_next       = val_reg;
        carry_next     = carry_reg;
        acc_next       = acc_reg;
        result_next    = result_reg;
        status_next    = status_reg;
        mem_addr       = cell_addr(row, col);
        mem_wdata      = '0;
        mem_we         = 1'b0;

        if (cfg_we)
        begin
            if (cfg_index == sate_pkg::CFG_ROWS)
                rows_cfg_next = cfg_data;
            else
                cols_cfg_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    result_next = '0;
                    status_next = sate_pkg::STATUS_OK;
                    if (phase_err)
                    begin
                        status_next = sate_pkg::STATUS_PHASE;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        case (op)
                            sate_pkg::OP_ADD, sate_pkg::OP_SET, sate_pkg::OP_GET:
                            begin
                                if (cell_oob)
                                begin
                                    status_next = sate_pkg::STATUS_RANGE;
                                    done_next   = 1'b1;
                                end
                                else if (op == sate_pkg::OP_SET)
                                begin
                                    mem_we      = 1'b1;
                                    mem_wdata   = value_ext;
                                    result_next = to_out(value_ext);
                                    done_next   = 1'b1;
                                end
                                else
                                begin
                                    // cell read issued now
                                    addr_next  = cell_addr(row, col);
                                    val_next   = value_ext;
                                    state_next = (op == sate_pkg::OP_ADD) ? ST_ADD : ST_GET;
                                end
                            end
                            sate_pkg::OP_BUILD:
                            begin
                                pass_next  = 1'b0;
                                outer_next = '0;
                                inner_next = '0;
                                carry_next = '0;
                                state_next = ST_BRD;
                            end
                            sate_pkg::OP_SUM:
                            begin
                                if (rect_oob)
                                begin
                                    status_next = sate_pkg::STATUS_RANGE;
                                    done_next   = 1'b1;
                                end
                                else
                                begin
                                    r_next     = row;
                                    c_next     = col;
                                    re_next    = row_end;
                                    ce_next    = col_end;
                                    k_next     = '0;
                                    acc_next   = '0;
                                    state_next = ST_SUM;
                                end
                            end
                            sate_pkg::OP_CLEAR:
                            begin
                                built_next     = 1'b0;
                                clr_cnt_next   = '0;
                                clr_reply_next = 1'b1;
                                state_next     = ST_CLR;
                            end
                            default:
                            begin
                                done_next = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_CLR:
            begin
                mem_addr     = clr_cnt_reg;
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    done_next   = clr_reply_reg;
                    result_next = '0;
                    status_next = sate_pkg::STATUS_OK;
                    state_next  = ST_IDLE;
                end
            end
            ST_ADD:
            begin
                mem_addr    = addr_reg;
                mem_we      = 1'b1;
                mem_wdata   = mem_rdata_reg + val_reg;
                result_next = to_out(mem_rdata_reg + val_reg);
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_GET:
            begin
                mem_addr    = addr_reg;
                result_next = to_out(mem_rdata_reg);
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_BRD:
            begin
                mem_addr   = build_addr;
                state_next = ST_BWR;
            end
            ST_BWR:
            begin
                mem_addr   = build_addr;
                mem_we     = 1'b1;
                mem_wdata  = bsum;
                state_next = ST_BRD;
                if (inner_last)
                begin
                    inner_next = '0;
                    carry_next = '0;
                    if (outer_last)
                    begin
                        outer_next = '0;
                        if (pass_reg)
                        begin
                            built_next  = 1'b1;
                            result_next = '0;
                            status_next = sate_pkg::STATUS_OK;
                            done_next   = 1'b1;
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            pass_next = 1'b1;
                        end
                    end
                    else
                    begin
                        outer_next = outer_reg + 7'd1;
                    end
                end
                else
                begin
                    inner_next = inner_reg + 7'd1;
                    carry_next = bsum;
                end
            end
            ST_SUM:
            begin
                // read of corner k issued, data of corner k-1 accumulated
                mem_addr  = cell_addr(corner_r - 7'd1, corner_c - 7'd1);
                zero_next = corner_zero;
                neg_next  = (k_reg == 3'd1) || (k_reg == 3'd2);
                k_next    = k_reg + 3'd1;
                if (k_reg != 3'd0)
                    acc_next = acc_reg + term;
                if (k_reg == 3'd4)
                begin
                    result_next = to_out(acc_reg + term);
                    status_next = sate_pkg::STATUS_OK;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            built_reg     <= 1'b0;
            rows_cfg_reg  <= sate_pkg::CFG_RESET;
            cols_cfg_reg  <= sate_pkg::CFG_RESET;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            pass_reg      <= 1'b0;
            outer_reg     <= '0;
            inner_reg     <= '0;
            k_reg         <= '0;
            zero_reg      <= 1'b0;
            neg_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            built_reg     <= built_next;
            rows_cfg_reg  <= rows_cfg_next;
            cols_cfg_reg  <= cols_cfg_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            pass_reg      <= pass_next;
            outer_reg     <= outer_next;
            inner_reg     <= inner_next;
            k_reg         <= k_next;
            zero_reg      <= zero_next;
            neg_reg       <= neg_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        c_reg      <= c_next;
        re_reg     <= re_next;
        ce_reg     <= ce_next;
        addr_reg   <= addr_next;
        val_reg    <= val_next;
        carry_reg  <= carry_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
        status_reg <= status_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = signed'(result_reg);
    assign status = status_reg;

`include "summed_area_table_engine_core_defines.svh"

    `SATE_ASSERT_NOW(a_sum_needs_built, state_reg == ST_SUM, built_reg && (k_reg <= 3'd4))
    `SATE_ASSERT_NOW(a_no_write_on_reads, (state_reg == ST_SUM) || (state_reg == ST_GET) || (state_reg == ST_BRD), !mem_we)
    `SATE_ASSERT_NEXT(a_rebuild_rejected, start && !busy && (op == sate_pkg::OP_BUILD) && built_reg, done && (status == sate_pkg::STATUS_PHASE))
    `SATE_ASSERT_NOW(a_build_reports, $rose(built_reg), done_reg && (status_reg == sate_pkg::STATUS_OK))

endmodule
